// ----- hdl/lc3is_pkg.sv -----
`timescale 1ns / 1ps
package lc3is_pkg;

  // Memory address width; higher address bits are ignored.
  localparam int ADDR_BITS = 16;

  localparam logic [15:0] KBSR_ADDR = 16'hFE00;
  localparam logic [15:0] KBDR_ADDR = 16'hFE02;
  localparam logic [15:0] START_RESET = 16'h3000;

  // Item operations; the last code is unused and only reports the state.
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_HALTED  = 2'd1;
  localparam logic [1:0] ST_BAD_OP  = 2'd2;
  localparam logic [1:0] ST_BAD_TRP = 2'd3;

  // Instruction opcodes.
  localparam logic [3:0] OPC_BR   = 4'd0;
  localparam logic [3:0] OPC_ADD  = 4'd1;
  localparam logic [3:0] OPC_LD   = 4'd2;
  localparam logic [3:0] OPC_ST   = 4'd3;
  localparam logic [3:0] OPC_JSR  = 4'd4;
  localparam logic [3:0] OPC_AND  = 4'd5;
  localparam logic [3:0] OPC_LDR  = 4'd6;
  localparam logic [3:0] OPC_STR  = 4'd7;
  localparam logic [3:0] OPC_RTI  = 4'd8;
  localparam logic [3:0] OPC_NOT  = 4'd9;
  localparam logic [3:0] OPC_LDI  = 4'd10;
  localparam logic [3:0] OPC_STI  = 4'd11;
  localparam logic [3:0] OPC_JMP  = 4'd12;
  localparam logic [3:0] OPC_RES  = 4'd13;
  localparam logic [3:0] OPC_LEA  = 4'd14;
  localparam logic [3:0] OPC_TRAP = 4'd15;

  // Trap vectors.
  localparam logic [7:0] VEC_GETC  = 8'h20;
  localparam logic [7:0] VEC_OUT   = 8'h21;
  localparam logic [7:0] VEC_PUTS  = 8'h22;
  localparam logic [7:0] VEC_IN    = 8'h23;
  localparam logic [7:0] VEC_PUTSP = 8'h24;
  localparam logic [7:0] VEC_HALT  = 8'h25;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_DATA,
    S_IND
  } state_t;

  // Source of the registered read data.
  typedef enum logic [1:0] {
    RS_MEM,
    RS_KBSR,
    RS_KBDR
  } rsel_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] load_address;
    logic [15:0] load_word;
    logic        key_ready;
    logic [7:0]  key_char;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] next_pc;
    logic        char_valid;
    logic [7:0]  out_char;
    logic [2:0]  cond_flags;
  } out_t;

  // Memory port request from the sequencer.
  typedef struct packed {
    logic                 rd_en;
    logic [ADDR_BITS-1:0] rd_addr;
    logic                 wr_en;
    logic [ADDR_BITS-1:0] wr_addr;
    logic [15:0]          wr_data;
  } mem_req_t;

endpackage

// ----- hdl/lc3is_mem.sv -----
`timescale 1ns / 1ps
module lc3is_mem (
  input  logic               clk,
  input  lc3is_pkg::mem_req_t req,
  output logic [15:0]        rd_data
);

  logic [15:0] mem [2**lc3is_pkg::ADDR_BITS];

  // Single-port-read, single-port-write word memory with registered read.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

endmodule

// ----- hdl/lc3_instruction_step_top.sv -----
`timescale 1ns / 1ps
// Load, start and halted-step items give their result in the cycle after the transfer.
// A step passes the fetch state, a data-read state for LD, LDR, LDI, STI and an indirect
// state for LDI (one read port). Loads and starts go every cycle while results leave;
// steps only in idle. An item is taken while a waiting result leaves at the edge.
// Reset: synchronous active-low; registers, PC and flags clear, the core is halted and
// the start address is 0x3000. Memory contents are undefined until written.
module lc3_instruction_step_top (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  lc3is_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output lc3is_pkg::out_t out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [15:0]     cfg_data
);

  localparam int AB = lc3is_pkg::ADDR_BITS;

  lc3is_pkg::state_t   state_r, state_nxt;
  lc3is_pkg::in_t      item_r, item_nxt;
  lc3is_pkg::out_t     out_r, out_nxt;
  lc3is_pkg::rsel_t    rsel_r, rsel_nxt;
  lc3is_pkg::mem_req_t req;
  logic                out_valid_r, out_valid_nxt;
  logic [15:0]         pc_r, pc_nxt;
  logic [2:0]          cc_r, cc_nxt;
  logic                halted_r, halted_nxt;
  logic [15:0]         start_r;
  logic [15:0]         regs_r [8];
  logic [15:0]         regs_nxt [8];
  logic [15:0]         instr_r, instr_nxt;
  logic [15:0]         kbsr_r, kbsr_nxt;
  logic [15:0]         kbdr_r, kbdr_nxt;
  logic [15:0]         mem_rdata, rdata, ins;
  logic                in_fire, finish;
  logic [1:0]          status;
  logic                cvalid;
  logic [7:0]          ochar;
  logic                key_rdy;
  logic [7:0]          key;
  logic                rd_req, wr_req;
  logic [15:0]         rd_addr16, wr_addr16, wr_data16;
  logic [2:0]          dr, sr1;
  logic [15:0]         off9, off6, off11, imm5, pc_off9, base_off6, opb, alu;

  function automatic logic [2:0] nzp(input logic [15:0] v);
    if (v == 16'd0) begin
      return 3'd2;
    end else if (v[15]) begin
      return 3'd4;
    end
    return 3'd1;
  endfunction

  lc3is_mem u_mem (
    .clk     (clk),
    .req     (req),
    .rd_data (mem_rdata)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == lc3is_pkg::S_IDLE) && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Keyboard registers are mirrored in flops; they shadow their memory words.
  always_comb begin
    case (rsel_r)
      lc3is_pkg::RS_KBSR: rdata = kbsr_r;
      lc3is_pkg::RS_KBDR: rdata = kbdr_r;
      default:            rdata = mem_rdata;
    endcase
  end

  // Instruction fields.
  assign ins       = (state_r == lc3is_pkg::S_FETCH) ? rdata : instr_r;
  assign dr        = ins[11:9];
  assign sr1       = ins[8:6];
  assign off9      = {{7{ins[8]}}, ins[8:0]};
  assign off6      = {{10{ins[5]}}, ins[5:0]};
  assign off11     = {{5{ins[10]}}, ins[10:0]};
  assign imm5      = {{11{ins[4]}}, ins[4:0]};
  assign pc_off9   = pc_r + off9;
  assign base_off6 = regs_r[sr1] + off6;
  assign opb       = ins[5] ? imm5 : regs_r[ins[2:0]];
  assign alu       = (ins[15:12] == lc3is_pkg::OPC_ADD) ? (regs_r[sr1] + opb)
                                                        : (regs_r[sr1] & opb);
  assign key_rdy   = (state_r == lc3is_pkg::S_IDLE) ? in_data.key_ready : item_r.key_ready;
  assign key       = (state_r == lc3is_pkg::S_IDLE) ? in_data.key_char : item_r.key_char;

  // Next state of the sequencer: data reads follow the fetch for loads and STI.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lc3is_pkg::S_IDLE: begin
        if (in_fire && (in_data.operation == lc3is_pkg::OP_STEP) && !halted_r) begin
          state_nxt = lc3is_pkg::S_FETCH;
        end
      end
      lc3is_pkg::S_FETCH: begin
        if (ins[15:12] inside {lc3is_pkg::OPC_LD, lc3is_pkg::OPC_LDI, lc3is_pkg::OPC_LDR,
                               lc3is_pkg::OPC_STI}) begin
          state_nxt = lc3is_pkg::S_DATA;
        end else begin
          state_nxt = lc3is_pkg::S_IDLE;
        end
      end
      lc3is_pkg::S_DATA: begin
        if (ins[15:12] == lc3is_pkg::OPC_LDI) begin
          state_nxt = lc3is_pkg::S_IND;
        end else begin
          state_nxt = lc3is_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = lc3is_pkg::S_IDLE;
      end
    endcase
  end

  // Sequencer outputs: fetch, execute and the dependent data reads of one item.
  always_comb begin
    item_nxt   = item_r;
    pc_nxt     = pc_r;
    cc_nxt     = cc_r;
    halted_nxt = halted_r;
    instr_nxt  = instr_r;
    for (int i = 0; i < 8; i++) begin
      regs_nxt[i] = regs_r[i];
    end
    finish    = 1'b0;
    status    = lc3is_pkg::ST_OK;
    cvalid    = 1'b0;
    ochar     = 8'd0;
    rd_req    = 1'b0;
    rd_addr16 = 16'd0;
    wr_req    = 1'b0;
    wr_addr16 = 16'd0;
    wr_data16 = 16'd0;
    case (state_r)
      lc3is_pkg::S_IDLE: begin
        if (in_fire) begin
          item_nxt = in_data;
          case (in_data.operation)
            lc3is_pkg::OP_LOAD: begin
              wr_req    = 1'b1;
              wr_addr16 = in_data.load_address;
              wr_data16 = in_data.load_word;
              finish    = 1'b1;
            end
            lc3is_pkg::OP_START: begin
              pc_nxt     = start_r;
              halted_nxt = 1'b0;
              finish     = 1'b1;
            end
            lc3is_pkg::OP_STEP: begin
              if (halted_r) begin
                status = lc3is_pkg::ST_HALTED;
                finish = 1'b1;
              end else begin
                rd_req    = 1'b1;
                rd_addr16 = pc_r;
                pc_nxt    = pc_r + 16'd1;
              end
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end
      lc3is_pkg::S_FETCH: begin
        instr_nxt = rdata;
        finish    = 1'b1;
        case (ins[15:12])
          lc3is_pkg::OPC_ADD, lc3is_pkg::OPC_AND: begin
            regs_nxt[dr] = alu;
            cc_nxt       = nzp(alu);
          end
          lc3is_pkg::OPC_NOT: begin
            regs_nxt[dr] = ~regs_r[sr1];
            cc_nxt       = nzp(~regs_r[sr1]);
          end
          lc3is_pkg::OPC_BR: begin
            if ((dr & cc_r) != 3'd0) begin
              pc_nxt = pc_off9;
            end
          end
          lc3is_pkg::OPC_JMP: begin
            pc_nxt = regs_r[sr1];
          end
          lc3is_pkg::OPC_JSR: begin
            pc_nxt      = ins[11] ? (pc_r + off11) : regs_r[sr1];
            regs_nxt[7] = pc_r;
          end
          lc3is_pkg::OPC_LD, lc3is_pkg::OPC_LDI, lc3is_pkg::OPC_STI: begin
            rd_req    = 1'b1;
            rd_addr16 = pc_off9;
            finish    = 1'b0;
          end
          lc3is_pkg::OPC_LDR: begin
            rd_req    = 1'b1;
            rd_addr16 = base_off6;
            finish    = 1'b0;
          end
          lc3is_pkg::OPC_LEA: begin
            regs_nxt[dr] = pc_off9;
            cc_nxt       = nzp(pc_off9);
          end
          lc3is_pkg::OPC_ST: begin
            wr_req    = 1'b1;
            wr_addr16 = pc_off9;
            wr_data16 = regs_r[dr];
          end
          lc3is_pkg::OPC_STR: begin
            wr_req    = 1'b1;
            wr_addr16 = base_off6;
            wr_data16 = regs_r[dr];
          end
          lc3is_pkg::OPC_TRAP: begin
            case (ins[7:0])
              lc3is_pkg::VEC_GETC: begin
                regs_nxt[0] = {8'd0, item_r.key_char};
              end
              lc3is_pkg::VEC_OUT: begin
                cvalid = 1'b1;
                ochar  = regs_r[0][7:0];
              end
              lc3is_pkg::VEC_IN: begin
                regs_nxt[0] = {8'd0, item_r.key_char};
                cvalid      = 1'b1;
                ochar       = item_r.key_char;
              end
              lc3is_pkg::VEC_HALT: begin
                halted_nxt = 1'b1;
                status     = lc3is_pkg::ST_HALTED;
              end
              lc3is_pkg::VEC_PUTS, lc3is_pkg::VEC_PUTSP: begin
                halted_nxt = 1'b1;
                status     = lc3is_pkg::ST_BAD_TRP;
              end
              default: begin
              end
            endcase
          end
          default: begin
            halted_nxt = 1'b1;
            status     = lc3is_pkg::ST_BAD_OP;
          end
        endcase
      end
      lc3is_pkg::S_DATA: begin
        case (ins[15:12])
          lc3is_pkg::OPC_LDI: begin
            rd_req    = 1'b1;
            rd_addr16 = rdata;
          end
          lc3is_pkg::OPC_STI: begin
            wr_req    = 1'b1;
            wr_addr16 = rdata;
            wr_data16 = regs_r[dr];
            finish    = 1'b1;
          end
          default: begin
            regs_nxt[dr] = rdata;
            cc_nxt       = nzp(rdata);
            finish       = 1'b1;
          end
        endcase
      end
      lc3is_pkg::S_IND: begin
        regs_nxt[dr] = rdata;
        cc_nxt       = nzp(rdata);
        finish       = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Memory requests, keyboard sampling and read data source.
  always_comb begin
    req.rd_en   = rd_req;
    req.rd_addr = rd_addr16[AB-1:0];
    req.wr_en   = wr_req;
    req.wr_addr = wr_addr16[AB-1:0];
    req.wr_data = wr_data16;
    kbsr_nxt    = kbsr_r;
    kbdr_nxt    = kbdr_r;
    rsel_nxt    = rsel_r;
    if (rd_req) begin
      if (rd_addr16 == lc3is_pkg::KBSR_ADDR) begin
        kbsr_nxt = key_rdy ? 16'h8000 : 16'h0000;
        if (key_rdy) begin
          kbdr_nxt = {8'd0, key};
        end
      end
      if (rd_addr16[AB-1:0] == lc3is_pkg::KBSR_ADDR[AB-1:0]) begin
        rsel_nxt = lc3is_pkg::RS_KBSR;
      end else if (rd_addr16[AB-1:0] == lc3is_pkg::KBDR_ADDR[AB-1:0]) begin
        rsel_nxt = lc3is_pkg::RS_KBDR;
      end else begin
        rsel_nxt = lc3is_pkg::RS_MEM;
      end
    end
    if (wr_req) begin
      if (wr_addr16[AB-1:0] == lc3is_pkg::KBSR_ADDR[AB-1:0]) begin
        kbsr_nxt = wr_data16;
      end
      if (wr_addr16[AB-1:0] == lc3is_pkg::KBDR_ADDR[AB-1:0]) begin
        kbdr_nxt = wr_data16;
      end
    end
  end

  // Result register; it is free again once its transfer completes.
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (finish) begin
      out_valid_nxt      = 1'b1;
      out_nxt.status     = status;
      out_nxt.next_pc    = pc_nxt;
      out_nxt.char_valid = cvalid;
      out_nxt.out_char   = ochar;
      out_nxt.cond_flags = cc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lc3is_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      pc_r        <= 16'd0;
      cc_r        <= 3'd0;
      halted_r    <= 1'b1;
      start_r     <= lc3is_pkg::START_RESET;
      rsel_r      <= lc3is_pkg::RS_MEM;
      for (int i = 0; i < 8; i++) begin
        regs_r[i] <= 16'd0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pc_r        <= pc_nxt;
      cc_r        <= cc_nxt;
      halted_r    <= halted_nxt;
      rsel_r      <= rsel_nxt;
      for (int i = 0; i < 8; i++) begin
        regs_r[i] <= regs_nxt[i];
      end
      if (cfg_valid && cfg_ready) begin
        start_r <= cfg_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    out_r   <= out_nxt;
    instr_r <= instr_nxt;
    kbsr_r  <= kbsr_nxt;
    kbdr_r  <= kbdr_nxt;
  end

endmodule

// ----- tb/sv/lc3_step_checker.sv -----
`timescale 1ns / 1ps
module lc3_step_checker (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_ready,
  input  lc3is_pkg::in_t  in_data,
  input  logic            out_valid,
  input  logic            out_ready,
  input  lc3is_pkg::out_t out_data,
  input  logic            cfg_valid,
  input  logic            cfg_ready,
  input  logic [15:0]     cfg_data,
  output int              mismatches,
  output int              outstanding
);

  localparam int AB    = lc3is_pkg::ADDR_BITS;
  localparam int WORDS = 1 << AB;

  // Shadow of the core's architectural state. The stimulus side reads it too.
  logic [15:0] mem [WORDS];
  bit          written [WORDS];
  logic [15:0] gpr [8];
  logic [15:0] pc;
  logic [2:0]  cc;
  bit          halted;
  logic [15:0] start_pc;

  lc3is_pkg::out_t expected_q [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic logic [15:0] sext_field(logic [15:0] v, int bits);
    logic [15:0] m;
    m = 16'hFFFF << bits;
    return v[bits-1] ? (v | m) : (v & ~m);
  endfunction

  function automatic void store_word(logic [15:0] a, logic [15:0] v);
    mem[a[AB-1:0]]     = v;
    written[a[AB-1:0]] = 1'b1;
  endfunction

  // A read of the keyboard status word samples the key fields first.
  function automatic logic [15:0] fetch_word(logic [15:0] a, logic rdy, logic [7:0] key);
    if (a == lc3is_pkg::KBSR_ADDR) begin
      if (rdy) begin
        store_word(lc3is_pkg::KBSR_ADDR, 16'h8000);
        store_word(lc3is_pkg::KBDR_ADDR, {8'h00, key});
      end else begin
        store_word(lc3is_pkg::KBSR_ADDR, 16'h0000);
      end
    end
    return mem[a[AB-1:0]];
  endfunction

  function automatic void set_flags(logic [15:0] v);
    if (v == 16'h0000) cc = 3'd2;
    else if (v[15]) cc = 3'd4;
    else cc = 3'd1;
  endfunction

  // Works out the result of one item and advances the shadow state.
  function automatic lc3is_pkg::out_t execute_item(lc3is_pkg::in_t it);
    lc3is_pkg::out_t r;
    logic [15:0]     w, npc, b, p;
    logic [2:0]      dr, sr1;
    r = '0;
    case (it.operation)
      lc3is_pkg::OP_LOAD: store_word(it.load_address, it.load_word);
      lc3is_pkg::OP_START: begin
        pc     = start_pc;
        halted = 1'b0;
      end
      lc3is_pkg::OP_STEP: begin
        if (halted) begin
          r.status = lc3is_pkg::ST_HALTED;
        end else begin
          w   = fetch_word(pc, it.key_ready, it.key_char);
          dr  = w[11:9];
          sr1 = w[8:6];
          pc  = pc + 16'd1;
          npc = pc;
          case (w[15:12])
            lc3is_pkg::OPC_ADD, lc3is_pkg::OPC_AND: begin
              b = w[5] ? sext_field(w, 5) : gpr[w[2:0]];
              gpr[dr] = (w[15:12] == lc3is_pkg::OPC_ADD) ? gpr[sr1] + b : gpr[sr1] & b;
              set_flags(gpr[dr]);
            end
            lc3is_pkg::OPC_NOT: begin
              gpr[dr] = ~gpr[sr1];
              set_flags(gpr[dr]);
            end
            lc3is_pkg::OPC_BR: if ((dr & cc) != 3'd0) pc = npc + sext_field(w, 9);
            lc3is_pkg::OPC_JMP: pc = gpr[sr1];
            lc3is_pkg::OPC_JSR: begin
              pc = w[11] ? npc + sext_field(w, 11) : gpr[sr1];
              gpr[7] = npc;
            end
            lc3is_pkg::OPC_LD: begin
              gpr[dr] = fetch_word(npc + sext_field(w, 9), it.key_ready, it.key_char);
              set_flags(gpr[dr]);
            end
            lc3is_pkg::OPC_LDI: begin
              p = fetch_word(npc + sext_field(w, 9), it.key_ready, it.key_char);
              gpr[dr] = fetch_word(p, it.key_ready, it.key_char);
              set_flags(gpr[dr]);
            end
            lc3is_pkg::OPC_LDR: begin
              gpr[dr] = fetch_word(gpr[sr1] + sext_field(w, 6), it.key_ready, it.key_char);
              set_flags(gpr[dr]);
            end
            lc3is_pkg::OPC_LEA: begin
              gpr[dr] = npc + sext_field(w, 9);
              set_flags(gpr[dr]);
            end
            lc3is_pkg::OPC_ST: store_word(npc + sext_field(w, 9), gpr[dr]);
            lc3is_pkg::OPC_STI: begin
              p = fetch_word(npc + sext_field(w, 9), it.key_ready, it.key_char);
              store_word(p, gpr[dr]);
            end
            lc3is_pkg::OPC_STR: store_word(gpr[sr1] + sext_field(w, 6), gpr[dr]);
            lc3is_pkg::OPC_TRAP: begin
              case (w[7:0])
                lc3is_pkg::VEC_GETC: gpr[0] = {8'h00, it.key_char};
                lc3is_pkg::VEC_OUT: begin
                  r.char_valid = 1'b1;
                  r.out_char   = gpr[0][7:0];
                end
                lc3is_pkg::VEC_IN: begin
                  gpr[0]       = {8'h00, it.key_char};
                  r.char_valid = 1'b1;
                  r.out_char   = it.key_char;
                end
                lc3is_pkg::VEC_HALT: begin
                  halted   = 1'b1;
                  r.status = lc3is_pkg::ST_HALTED;
                end
                lc3is_pkg::VEC_PUTS, lc3is_pkg::VEC_PUTSP: begin
                  halted   = 1'b1;
                  r.status = lc3is_pkg::ST_BAD_TRP;
                end
                default: ;
              endcase
            end
            default: begin
              halted   = 1'b1;
              r.status = lc3is_pkg::ST_BAD_OP;
            end
          endcase
        end
      end
      default: ;
    endcase
    r.next_pc    = pc;
    r.cond_flags = cc;
    return r;
  endfunction

  task automatic report(string field, logic [15:0] got, logic [15:0] want);
    $display("%0t: %s is %h, %h was predicted", $realtime, field, got, want);
    mismatches++;
  endtask

  // Follows every transfer on the three channels.
  always @(posedge clk) begin
    lc3is_pkg::out_t want;
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) gpr[i] = 16'h0000;
      pc       = 16'h0000;
      cc       = 3'd0;
      halted   = 1'b1;
      start_pc = lc3is_pkg::START_RESET;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) start_pc = cfg_data;
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected result, next_pc", out_data.next_pc, 16'h0000);
        end else begin
          want = expected_q.pop_front();
          if (out_data.status !== want.status)
            report("status", 16'(out_data.status), 16'(want.status));
          if (out_data.next_pc !== want.next_pc)
            report("next_pc", out_data.next_pc, want.next_pc);
          if (out_data.char_valid !== want.char_valid)
            report("char_valid", 16'(out_data.char_valid), 16'(want.char_valid));
          if (out_data.out_char !== want.out_char)
            report("out_char", 16'(out_data.out_char), 16'(want.out_char));
          if (out_data.cond_flags !== want.cond_flags)
            report("cond_flags", 16'(out_data.cond_flags), 16'(want.cond_flags));
        end
      end
      if (in_valid && in_ready) expected_q.push_back(execute_item(in_data));
    end
    outstanding = expected_q.size();
  end

endmodule

// ----- tb/sv/lc3_instruction_step_top_test.sv -----
`timescale 1ns / 1ps
module lc3_instruction_step_top_test;

  localparam int PHASE_ITEMS = 280;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 150;
  localparam int AB          = lc3is_pkg::ADDR_BITS;

  logic            clk;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  lc3is_pkg::in_t  in_data = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  lc3is_pkg::out_t out_data;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [15:0]     cfg_data = 16'h0000;

  int          mismatches;
  int          outstanding;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          item_count = 0;
  bit          holding = 1'b0;
  bit          hold_done = 1'b0;
  int          quiet_cycles = 0;
  event        hold_req;

  lc3_instruction_step_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  lc3_step_checker i_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // The receiver stalls at random, and stalls throughout a long hold-off.
  always @(negedge clk) begin
    out_ready <= !holding && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  initial begin
    forever begin
      @(hold_req);
      holding = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      holding = 1'b0;
    end
  end

  // Ends the run if no transfer happens for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [15:0] sext_field(logic [15:0] v, int bits);
    logic [15:0] m;
    m = 16'hFFFF << bits;
    return v[bits-1] ? (v | m) : (v & ~m);
  endfunction

  // Random instruction word, weighted so that halting stays uncommon.
  function automatic logic [15:0] random_instruction();
    int          pick;
    logic [15:0] w;
    logic [7:0]  vec;
    pick = $urandom_range(0, 99);
    w = 16'($urandom);
    if (pick < 8) w[15:12] = lc3is_pkg::OPC_ADD;
    else if (pick < 16) w[15:12] = lc3is_pkg::OPC_AND;
    else if (pick < 22) w[15:12] = lc3is_pkg::OPC_NOT;
    else if (pick < 32) w[15:12] = lc3is_pkg::OPC_BR;
    else if (pick < 36) w[15:12] = lc3is_pkg::OPC_JMP;
    else if (pick < 42) w[15:12] = lc3is_pkg::OPC_JSR;
    else if (pick < 50) w[15:12] = lc3is_pkg::OPC_LD;
    else if (pick < 56) w[15:12] = lc3is_pkg::OPC_LDI;
    else if (pick < 64) w[15:12] = lc3is_pkg::OPC_LDR;
    else if (pick < 70) w[15:12] = lc3is_pkg::OPC_LEA;
    else if (pick < 76) w[15:12] = lc3is_pkg::OPC_ST;
    else if (pick < 80) w[15:12] = lc3is_pkg::OPC_STI;
    else if (pick < 86) w[15:12] = lc3is_pkg::OPC_STR;
    else if (pick < 99) begin
      w[15:12] = lc3is_pkg::OPC_TRAP;
      case ($urandom_range(0, 12))
        0: vec = lc3is_pkg::VEC_HALT;
        1: vec = lc3is_pkg::VEC_PUTS;
        2: vec = lc3is_pkg::VEC_PUTSP;
        3, 4: vec = 8'($urandom);
        5, 6, 7: vec = lc3is_pkg::VEC_GETC;
        8, 9: vec = lc3is_pkg::VEC_IN;
        default: vec = lc3is_pkg::VEC_OUT;
      endcase
      w[7:0] = vec;
    end else begin
      w[15:12] = $urandom_range(0, 1) ? lc3is_pkg::OPC_RTI : lc3is_pkg::OPC_RES;
    end
    return w;
  endfunction

  // Offers one item and returns at the falling edge after its transfer.
  task automatic send_item(logic [1:0] op, logic [15:0] addr, logic [15:0] word,
                           logic rdy, logic [7:0] key);
    lc3is_pkg::in_t it;
    it.operation    = op;
    it.load_address = addr;
    it.load_word    = word;
    it.key_ready    = rdy;
    it.key_char     = key;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (op != lc3is_pkg::OP_NONE) item_count++;
  endtask

  task automatic load_word(logic [15:0] addr, logic [15:0] word);
    send_item(lc3is_pkg::OP_LOAD, addr, word, 1'($urandom_range(0, 1)), 8'($urandom));
  endtask

  task automatic start_core();
    send_item(lc3is_pkg::OP_START, 16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)),
              8'($urandom));
  endtask

  // Writes a word wherever the next step would read one never written.
  task automatic cover_read(logic [15:0] addr);
    if (addr != lc3is_pkg::KBSR_ADDR && !i_check.written[addr[AB-1:0]])
      load_word(addr, ($urandom_range(0, 3) == 0) ? lc3is_pkg::KBSR_ADDR : 16'($urandom));
  endtask

  // One instruction step; the program word is chosen here if none is stored.
  task automatic step_core(bit forced, logic [15:0] instr);
    logic        rdy;
    logic [7:0]  key;
    logic [15:0] at, w, npc, a;
    rdy = 1'($urandom_range(0, 1));
    key = 8'($urandom);
    if (!i_check.halted) begin
      at = i_check.pc;
      if (at != lc3is_pkg::KBSR_ADDR && !i_check.written[at[AB-1:0]])
        load_word(at, forced ? instr : random_instruction());
      w   = (at == lc3is_pkg::KBSR_ADDR) ? (rdy ? 16'h8000 : 16'h0000)
                                         : i_check.mem[at[AB-1:0]];
      npc = at + 16'd1;
      case (w[15:12])
        lc3is_pkg::OPC_LD, lc3is_pkg::OPC_STI: cover_read(npc + sext_field(w, 9));
        lc3is_pkg::OPC_LDR: cover_read(i_check.gpr[w[8:6]] + sext_field(w, 6));
        lc3is_pkg::OPC_LDI: begin
          a = npc + sext_field(w, 9);
          cover_read(a);
          cover_read((a == lc3is_pkg::KBSR_ADDR) ? (rdy ? 16'h8000 : 16'h0000)
                                                 : i_check.mem[a[AB-1:0]]);
        end
        default: ;
      endcase
    end
    send_item(lc3is_pkg::OP_STEP, 16'($urandom), 16'($urandom), rdy, key);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_start(logic [15:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  logic [15:0] directed_prog [] = '{
    16'h127F, 16'h1441, 16'h5660, 16'h5842, 16'h9AFF, 16'h0E00, 16'hED00,
    16'h2005, 16'hA003, 16'h61A0, 16'h3202, 16'hB204, 16'h759F, 16'hF020,
    16'hF021, 16'hF023, 16'hF0FF, 16'h4801, 16'h41C0, 16'hC1C0, 16'hF025,
    16'hD000, 16'h8000, 16'hF022, 16'hF024
  };

  logic [15:0] phase_start [5];

  initial begin
    phase_start = '{16'h0000, 16'hFFFF, 16'($urandom), 16'hFFF0, 16'($urandom)};
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: an idle core, an unused operation, then each instruction kind.
    write_start(lc3is_pkg::START_RESET);
    step_core(1'b0, 16'h0000);
    send_item(lc3is_pkg::OP_NONE, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF);
    start_core();
    foreach (directed_prog[i]) begin
      step_core(1'b1, directed_prog[i]);
      if (i_check.halted) start_core();
    end

    // Random part, one phase per start address and idling pattern.
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      write_start(phase_start[ph]);
      case (ph)
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        3: begin send_idle_pct = 18; recv_stall_pct = 18; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      start_core();
      item_count = 0;
      while (item_count < PHASE_ITEMS) begin
        if (ph == 0 && !hold_done && item_count >= 40) begin
          -> hold_req;
          hold_done = 1'b1;
        end
        if (i_check.halted) begin
          if ($urandom_range(0, 9) < 7) start_core();
          else step_core(1'b0, 16'h0000);
        end else begin
          case ($urandom_range(0, 99))
            0, 1, 2: start_core();
            3, 4: send_item(lc3is_pkg::OP_NONE, 16'($urandom), 16'($urandom),
                            1'($urandom_range(0, 1)), 8'($urandom));
            5, 6, 7: load_word(16'($urandom), 16'($urandom));
            default: step_core(1'b0, 16'h0000);
          endcase
        end
      end
    end

    drain();
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
